FILE: rtl/aad_pkg.sv
// Package for the area-average downscaler.
// Shared types, widths, size limits and the overlap split helper. No dependencies.
`timescale 1ns / 1ps

package aad_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int PW = 27;

	typedef struct packed {
		logic [12:0] sw;
		logic [12:0] cw;
		logic [12:0] ch;
		logic [12:0] dw;
		logic [12:0] dh;
		logic [11:0] left;
		logic [11:0] top;
		logic        gray;
	} aad_cfg_t;

	typedef struct packed {
		logic [31:0] acc_r;
		logic [31:0] acc_g;
		logic [31:0] acc_b;
		logic [11:0] col;
		logic [11:0] row;
		logic        rend;
		logic        fend;
	} aad_res_t;

	typedef struct packed {
		logic [12:0] w0;
		logic [12:0] w1;
		logic        done;
	} aad_split_t;

	function automatic logic [12:0] aad_clamp(input logic [12:0] v, input int hi);
		logic [12:0] r;
		if (v == 13'd0) begin
			r = 13'd1;
		end else if (int'(v) > hi) begin
			r = 13'(hi);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// overlap of [lo, lo+len) against a span that ends at b
	function automatic aad_split_t aad_split(input logic [PW-1:0] lo, input logic [12:0] len,
		input logic [PW-1:0] b);
		logic [PW-1:0] hi;
		logic [PW-1:0] m;
		aad_split_t    s;
		hi = lo + PW'(len);
		if (hi < b) begin
			s.w0   = len;
			s.w1   = 13'd0;
			s.done = 1'b0;
		end else begin
			m      = (b > lo) ? b : lo;
			s.w0   = (b > lo) ? 13'(b - lo) : 13'd0;
			s.w1   = 13'(hi - m);
			s.done = 1'b1;
		end
		return s;
	endfunction

endpackage

FILE: rtl/aad_fifo.sv
// Short queue between the accumulation front and the divider back end.
// Uses aad_pkg for the result type.
`timescale 1ns / 1ps

module aad_fifo
	import aad_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  aad_res_t push_data,
	output logic     full,
	input  logic     pop,
	output aad_res_t pop_data,
	output logic     empty
);

	localparam int DEPTH = 4;

	aad_res_t    mem_q [DEPTH];
	logic [1:0]  wp_q;
	logic [1:0]  rp_q;
	logic [2:0]  cnt_q;

	assign full     = (cnt_q == 3'(DEPTH));
	assign empty    = (cnt_q == 3'd0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= wp_q + 2'd1;
			end
			if (pop && !empty) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push && !full) - 3'(pop && !empty);
		end
	end

endmodule

FILE: rtl/aad_front.sv
// Front end: tracks source and output position, weights each pixel and folds
// it into the row accumulators. Uses aad_pkg; feeds aad_fifo.
`timescale 1ns / 1ps

module aad_front
	import aad_pkg::*;
#(
	parameter int AW = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  aad_cfg_t    cfg,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	output logic        push,
	output aad_res_t    push_data,
	input  logic        full
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SPLIT = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_PROD  = 3'd4;
	localparam logic [2:0] ST_ACC   = 3'd5;

	logic [2:0]  state_q;
	logic [11:0] col_q;
	logic [12:0] row_q;
	logic [12:0] dstc_q;
	logic [12:0] dstr_q;
	logic [31:0] hs_q [3];

	logic [11:0] col_s1;
	logic [12:0] row_s1;
	logic [11:0] c_s1;
	logic [12:0] r_s1;
	logic [12:0] x_s1;
	logic [12:0] y_s1;
	logic [7:0]  pix_s1 [3];
	logic        eol_s1;
	logic        inwin_s1;
	logic        rowok_s1;

	logic [PW-1:0] lox_s2;
	logic [PW-1:0] bx_s2;
	logic [PW-1:0] loy_s2;
	logic [PW-1:0] by_s2;

	aad_split_t  wx_s3;
	aad_split_t  wy_s3;
	logic        first_s3;

	logic [31:0] h_s4 [3];
	logic [31:0] p0_s5 [3];
	logic [31:0] p1_s5 [3];
	logic [31:0] rd_q [3];
	logic [31:0] acc [3];

	logic        accept;
	logic        fs;
	logic [11:0] col_e;
	logic [12:0] row_e;
	logic [12:0] dstc_e;
	logic [12:0] dstr_e;
	logic        ignore;
	logic [11:0] cin;
	logic        inwin;
	logic        eol;
	logic        rowok;
	logic        rowinc;
	logic        finish;
	logic [AW-1:0] idx;
	logic        ypar;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign fs       = s_tuser;
	assign col_e    = fs ? 12'd0 : col_q;
	assign row_e    = fs ? 13'd0 : row_q;
	assign dstc_e   = fs ? 13'd0 : dstc_q;
	assign dstr_e   = fs ? 13'd0 : dstr_q;
	assign ignore   = {1'b0, row_e} >= (14'(cfg.top) + 14'(cfg.ch));
	assign cin      = col_e - cfg.left;
	assign rowok    = (row_e >= 13'(cfg.top)) && (dstr_e < cfg.dh);
	assign inwin    = rowok && (col_e >= cfg.left) && ({1'b0, cin} < cfg.cw)
		&& (dstc_e < cfg.dw);
	assign eol      = (13'(col_e) + 13'd1) >= cfg.sw;

	assign rowinc   = rowok_s1 && ((loy_s2 + PW'(cfg.dh)) >= by_s2);
	assign idx      = AW'(x_s1);
	assign ypar     = y_s1[0];

	always_comb begin
		finish = 1'b0;
		case (state_q)
			ST_SPLIT: finish = !inwin_s1;
			ST_SUM:   finish = !wx_s3.done;
			ST_ACC:   finish = !(wy_s3.done && full);
			default:  finish = 1'b0;
		endcase
	end

	assign push = (state_q == ST_ACC) && wy_s3.done && !full;
	assign push_data.acc_r = acc[0];
	assign push_data.acc_g = acc[1];
	assign push_data.acc_b = acc[2];
	assign push_data.col   = x_s1[11:0];
	assign push_data.row   = y_s1[11:0];
	assign push_data.rend  = (x_s1 + 13'd1) == cfg.dw;
	assign push_data.fend  = ((x_s1 + 13'd1) == cfg.dw) && ((y_s1 + 13'd1) == cfg.dh);

	for (genvar k = 0; k < 3; k++) begin : g_ch
		logic [31:0] bank0 [2**AW];
		logic [31:0] bank1 [2**AW];

		assign acc[k] = (first_s3 ? 32'd0 : rd_q[k]) + p0_s5[k];

		always_ff @(posedge clk) begin
			if (state_q == ST_SPLIT) begin
				rd_q[k] <= ypar ? bank1[idx] : bank0[idx];
			end
			if (state_q == ST_ACC) begin
				if (!ypar) begin
					bank0[idx] <= acc[k];
				end else if (wy_s3.w1 != 13'd0) begin
					bank0[idx] <= p1_s5[k];
				end
				if (ypar) begin
					bank1[idx] <= acc[k];
				end else if (wy_s3.w1 != 13'd0) begin
					bank1[idx] <= p1_s5[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1    <= col_e;
			row_s1    <= row_e;
			c_s1      <= cin;
			r_s1      <= row_e - 13'(cfg.top);
			x_s1      <= dstc_e;
			y_s1      <= dstr_e;
			pix_s1[0] <= s_tdata[7:0];
			pix_s1[1] <= cfg.gray ? s_tdata[7:0] : s_tdata[15:8];
			pix_s1[2] <= cfg.gray ? s_tdata[7:0] : s_tdata[23:16];
			eol_s1    <= eol;
			inwin_s1  <= inwin;
			rowok_s1  <= rowok;
		end
		if (state_q == ST_MUL) begin
			lox_s2 <= PW'(c_s1) * PW'(cfg.dw);
			bx_s2  <= PW'(x_s1 + 13'd1) * PW'(cfg.cw);
			loy_s2 <= PW'(r_s1) * PW'(cfg.dh);
			by_s2  <= PW'(y_s1 + 13'd1) * PW'(cfg.ch);
		end
		if (state_q == ST_SPLIT) begin
			wx_s3    <= aad_split(lox_s2, cfg.dw, bx_s2);
			wy_s3    <= aad_split(loy_s2, cfg.dh, by_s2);
			first_s3 <= loy_s2 == (by_s2 - PW'(cfg.ch));
		end
		for (int k = 0; k < 3; k++) begin
			if (state_q == ST_SUM) begin
				h_s4[k] <= hs_q[k] + 32'(pix_s1[k]) * 32'(wx_s3.w0);
			end
			if (state_q == ST_PROD) begin
				p0_s5[k] <= h_s4[k] * 32'(wy_s3.w0);
				p1_s5[k] <= h_s4[k] * 32'(wy_s3.w1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			dstc_q  <= '0;
			dstr_q  <= '0;
			for (int k = 0; k < 3; k++) begin
				hs_q[k] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && !ignore && (inwin || eol)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:   state_q <= ST_SPLIT;
				ST_SPLIT: state_q <= inwin_s1 ? ST_SUM : ST_IDLE;
				ST_SUM:   state_q <= wx_s3.done ? ST_PROD : ST_IDLE;
				ST_PROD:  state_q <= ST_ACC;
				ST_ACC: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (accept) begin
				col_q  <= (!ignore && !inwin && !eol) ? col_e + 12'd1 : col_e;
				row_q  <= row_e;
				dstc_q <= dstc_e;
				dstr_q <= dstr_e;
			end else if (finish) begin
				if (eol_s1) begin
					col_q  <= '0;
					dstc_q <= '0;
					row_q  <= row_s1 + 13'd1;
					dstr_q <= rowinc ? y_s1 + 13'd1 : y_s1;
				end else begin
					col_q  <= col_s1 + 12'd1;
					row_q  <= row_s1;
					dstr_q <= y_s1;
					dstc_q <= (state_q == ST_ACC) ? x_s1 + 13'd1 : x_s1;
				end
			end

			for (int k = 0; k < 3; k++) begin
				if ((accept && fs) || (finish && eol_s1)) begin
					hs_q[k] <= '0;
				end else if (state_q == ST_SUM) begin
					hs_q[k] <= wx_s3.done ? 32'(pix_s1[k]) * 32'(wx_s3.w1)
						: hs_q[k] + 32'(pix_s1[k]) * 32'(wx_s3.w0);
				end
			end
		end
	end

endmodule

FILE: rtl/aad_div.sv
// Back end: divides each accumulated channel by the window area, clamps to
// 255 and holds the result for the output stream. Uses aad_pkg.
`timescale 1ns / 1ps

module aad_div
	import aad_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  aad_cfg_t    cfg,
	output logic        pop,
	input  aad_res_t    pop_data,
	input  logic        empty,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tuser
);

	logic        busy_q;
	logic        fin_q;
	logic [2:0]  cnt_q;
	logic [32:0] d_q;
	logic [31:0] rem_q [3];
	logic [7:0]  quo_q [3];
	logic        sat_q [3];
	logic [11:0] col_q;
	logic [11:0] row_q;
	logic        rend_q;
	logic        fend_q;
	logic        out_v_q;
	logic [47:0] out_d_q;
	logic        out_l_q;
	logic        out_u_q;

	logic [25:0] area;
	logic [31:0] acc_in [3];
	logic        load;
	logic [7:0]  res [3];

	assign area      = 26'(cfg.cw) * 26'(cfg.ch);
	assign acc_in[0] = pop_data.acc_r;
	assign acc_in[1] = pop_data.acc_g;
	assign acc_in[2] = pop_data.acc_b;
	assign pop       = !busy_q && !empty;
	assign load      = busy_q && fin_q && (!out_v_q || m_tready);

	for (genvar k = 0; k < 3; k++) begin : g_res
		assign res[k] = sat_q[k] ? 8'hFF : quo_q[k];
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tlast  = out_l_q;
	assign m_tuser  = out_u_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			d_q    <= 33'(area) << 7;
			col_q  <= pop_data.col;
			row_q  <= pop_data.row;
			rend_q <= pop_data.rend;
			fend_q <= pop_data.fend;
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= acc_in[k];
				quo_q[k] <= '0;
				sat_q[k] <= 34'(acc_in[k]) >= (34'(area) << 8);
			end
		end else if (busy_q && !fin_q) begin
			d_q <= d_q >> 1;
			for (int k = 0; k < 3; k++) begin
				if (33'(rem_q[k]) >= d_q) begin
					rem_q[k] <= 32'(33'(rem_q[k]) - d_q);
					quo_q[k] <= {quo_q[k][6:0], 1'b1};
				end else begin
					quo_q[k] <= {quo_q[k][6:0], 1'b0};
				end
			end
		end
		if (load) begin
			out_d_q <= {row_q, col_q, res[2], res[1], res[0]};
			out_l_q <= rend_q;
			out_u_q <= fend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fin_q   <= 1'b0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				cnt_q  <= 3'd7;
			end else if (busy_q && !fin_q) begin
				if (cnt_q == 3'd0) begin
					fin_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 3'd1;
				end
			end else if (load) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b0;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/area_average_image_downscaler.sv
// Area-average image downscaler, top level: config registers, front, queue, divider.
// A pixel that closes an output pixel passes front states MUL, SPLIT, SUM, PROD, ACC,
// the queue and the divider with its output register. The front takes one pixel per
// cycle outside the window; at a row end or inside it, it waits to be back in IDLE (ACC
// stalls on a full queue); the divider pops no request until its result is loaded.
// Reset clears positions, sums and the queue; accumulator memories are not cleared.
`timescale 1ns / 1ps

module area_average_image_downscaler
	import aad_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pix_red, pix_green, pix_blue
	input  logic        s_tuser,   // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_red, out_green, out_blue, out_col, out_row
	output logic        m_tlast,   // row_end
	output logic        m_tuser    // frame_end
);

	localparam int AW = $clog2(MAX_WIDTH);

	localparam logic [2:0] REG_SRC_W  = 3'd0;
	localparam logic [2:0] REG_LEFT   = 3'd1;
	localparam logic [2:0] REG_TOP    = 3'd2;
	localparam logic [2:0] REG_CROP_W = 3'd3;
	localparam logic [2:0] REG_CROP_H = 3'd4;
	localparam logic [2:0] REG_DST_W  = 3'd5;
	localparam logic [2:0] REG_DST_H  = 3'd6;
	localparam logic [2:0] REG_GRAY   = 3'd7;

	logic [12:0] src_w_q;
	logic [11:0] left_q;
	logic [11:0] top_q;
	logic [12:0] crop_w_q;
	logic [12:0] crop_h_q;
	logic [12:0] dst_w_q;
	logic [12:0] dst_h_q;
	logic        gray_q;

	aad_cfg_t    cfg;
	logic [12:0] dw_c;
	logic [12:0] dh_c;
	logic        push;
	aad_res_t    push_data;
	logic        full;
	logic        pop;
	aad_res_t    pop_data;
	logic        empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q  <= 13'd4096;
			left_q   <= '0;
			top_q    <= '0;
			crop_w_q <= 13'd4096;
			crop_h_q <= 13'd4096;
			dst_w_q  <= 13'd4096;
			dst_h_q  <= 13'd4096;
			gray_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_W:  src_w_q  <= cfg_data;
				REG_LEFT:   left_q   <= cfg_data[11:0];
				REG_TOP:    top_q    <= cfg_data[11:0];
				REG_CROP_W: crop_w_q <= cfg_data;
				REG_CROP_H: crop_h_q <= cfg_data;
				REG_DST_W:  dst_w_q  <= cfg_data;
				REG_DST_H:  dst_h_q  <= cfg_data;
				REG_GRAY:   gray_q   <= cfg_data[0];
				default:    gray_q   <= gray_q;
			endcase
		end
	end

	always_comb begin
		cfg.sw   = aad_clamp(src_w_q, MAX_WIDTH);
		cfg.cw   = aad_clamp(crop_w_q, MAX_WIDTH);
		cfg.ch   = aad_clamp(crop_h_q, MAX_HEIGHT);
		dw_c     = aad_clamp(dst_w_q, MAX_WIDTH);
		dh_c     = aad_clamp(dst_h_q, MAX_HEIGHT);
		cfg.dw   = (dw_c > cfg.cw) ? cfg.cw : dw_c;
		cfg.dh   = (dh_c > cfg.ch) ? cfg.ch : dh_c;
		cfg.left = left_q;
		cfg.top  = top_q;
		cfg.gray = gray_q;
	end

	aad_front #(
		.AW(AW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	aad_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	aad_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pop     (pop),
		.pop_data(pop_data),
		.empty   (empty),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	a_fend_rend: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end without row end");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("request pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("request popped from an empty queue");

endmodule
